>>> rtl/assert_macros.svh
// Assertion macros used by the checker of the merge block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, quiet while rst_ni is low.
`define KWM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("k_way_merge port check failed");

// Next-cycle implication, sampled on clk_i, quiet while rst_ni is low.
`define KWM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("k_way_merge port check failed");

`endif

>>> rtl/kwm_pkg.sv
// Types and codes shared by the merge block and its checker.
package kwm_pkg;

  localparam logic [1:0] ACT_APPEND = 2'd0;
  localparam logic [1:0] ACT_POP    = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPEND,
    ST_SCAN,
    ST_DONE,
    ST_MISC
  } state_e;

  typedef struct packed {
    logic ram_we;
    logic wr_inc;
    logic rd_inc;
    logic clr_all;
    logic res_load;
  } ctrl_t;

endpackage

>>> rtl/k_way_merge.sv
// Top level of the k-way merge block: list storage, positions and scan sequencer.
//
// The block keeps NUM_LISTS lists of signed 32-bit words, each up to
// LIST_DEPTH words deep, in one shared RAM. A command word is taken at the
// rising edge where start is high and busy is low; busy then stays high until
// the answer appears. Exactly one result word comes back per command, shown on
// merged_value_o, source_list_o and status_o for a single cycle while done_o is
// high. The receiver cannot stall: a result not taken in that cycle is gone.
// An append is handled in ST_APPEND, a clear or an unknown action in ST_MISC;
// a pop goes through ST_SCAN and ST_DONE, and its time is set by the head
// scan, which walks the lists one per cycle through a single RAM read port and
// one shared signed comparator that sees each head after the registered RAM
// read. A new command may be issued in the same cycle that done_o is high.
// There is no clearing pass after reset: positions reset to zero, and RAM
// words are only used below a list's write position, so stale contents are
// never seen.
module k_way_merge #(
  parameter int NUM_LISTS  = 8,
  parameter int LIST_DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         action_i,
  input  logic [2:0]         list_number_i,
  input  logic signed [31:0] value_i,
  output logic               done_o,
  output logic signed [31:0] merged_value_o,
  output logic [2:0]         source_list_o,
  output logic [1:0]         status_o
);

  localparam int LW    = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
  localparam int CW    = $clog2(NUM_LISTS + 1);
  localparam int PW    = $clog2(LIST_DEPTH + 1);
  localparam int DEPTH = NUM_LISTS * LIST_DEPTH;
  localparam int AW    = $clog2(DEPTH);

  kwm_pkg::state_e state_q, state_d;
  kwm_pkg::ctrl_t  ctrl;

  // Latched command.
  logic [1:0]         act_q;
  logic [2:0]         list_q;
  logic signed [31:0] value_q;

  // Per-list positions, cleared at reset and by a clear command.
  logic [PW-1:0] wr_pos_q [NUM_LISTS];
  logic [PW-1:0] rd_pos_q [NUM_LISTS];

  // Scan state.
  logic [CW-1:0]      cnt_q;
  logic               cand_vld_q;
  logic [LW-1:0]      cand_idx_q;
  logic               found_q;
  logic [LW-1:0]      best_q;
  logic signed [31:0] best_val_q;

  // Result registers.
  logic               done_q;
  logic signed [31:0] res_val_q;
  logic [2:0]         res_src_q;
  logic [1:0]         res_stat_q;

  logic               accept;
  logic               issue;
  logic               scan_end;
  logic [LW-1:0]      pos_idx;
  logic [PW-1:0]      wr_sel;
  logic [PW-1:0]      rd_sel;
  logic               list_in_range;
  logic               append_ok;
  logic [AW-1:0]      ram_addr;
  logic [31:0]        ram_rdata;
  logic               take;

  assign accept   = start && (state_q == kwm_pkg::ST_IDLE);
  assign busy     = (state_q != kwm_pkg::ST_IDLE);
  assign issue    = (state_q == kwm_pkg::ST_SCAN) && (cnt_q < CW'(NUM_LISTS));
  assign scan_end = (cnt_q == CW'(NUM_LISTS));

  // One index port onto the position arrays, shared by append, scan and pop.
  always_comb begin
    case (state_q)
      kwm_pkg::ST_APPEND: pos_idx = LW'(list_q);
      kwm_pkg::ST_SCAN:   pos_idx = issue ? cnt_q[LW-1:0] : '0;
      kwm_pkg::ST_DONE:   pos_idx = best_q;
      default:            pos_idx = '0;
    endcase
  end

  assign list_in_range = (32'(list_q) < NUM_LISTS);
  assign wr_sel    = list_in_range || (state_q != kwm_pkg::ST_APPEND) ? wr_pos_q[pos_idx] : '0;
  assign rd_sel    = rd_pos_q[pos_idx];
  assign append_ok = list_in_range && (wr_sel < PW'(LIST_DEPTH));

  // List i starts at word i * LIST_DEPTH; appends use the write position,
  // reads use the read position.
  assign ram_addr = AW'(pos_idx) * AW'(LIST_DEPTH) +
                    ((state_q == kwm_pkg::ST_APPEND) ? AW'(wr_sel) : AW'(rd_sel));

  kwm_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl.ram_we),
    .waddr_i (ram_addr),
    .wdata_i (value_q),
    .raddr_i (ram_addr),
    .rdata_o (ram_rdata)
  );

  // Shared comparator: the head read in the previous cycle against the best so far.
  // Strictly less keeps the lowest-numbered list on ties.
  assign take = cand_vld_q && (!found_q || ($signed(ram_rdata) < best_val_q));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      kwm_pkg::ST_IDLE: begin
        if (accept) begin
          case (action_i)
            kwm_pkg::ACT_APPEND: state_d = kwm_pkg::ST_APPEND;
            kwm_pkg::ACT_POP:    state_d = kwm_pkg::ST_SCAN;
            default:             state_d = kwm_pkg::ST_MISC;
          endcase
        end
      end
      kwm_pkg::ST_APPEND: state_d = kwm_pkg::ST_IDLE;
      kwm_pkg::ST_SCAN: begin
        if (scan_end) begin
          state_d = kwm_pkg::ST_DONE;
        end
      end
      kwm_pkg::ST_DONE: state_d = kwm_pkg::ST_IDLE;
      kwm_pkg::ST_MISC: state_d = kwm_pkg::ST_IDLE;
      default:          state_d = kwm_pkg::ST_IDLE;
    endcase
  end

  // Control strobes.
  always_comb begin
    ctrl = '0;
    case (state_q)
      kwm_pkg::ST_APPEND: begin
        ctrl.ram_we   = append_ok;
        ctrl.wr_inc   = append_ok;
        ctrl.res_load = 1'b1;
      end
      kwm_pkg::ST_DONE: begin
        ctrl.rd_inc   = found_q;
        ctrl.res_load = 1'b1;
      end
      kwm_pkg::ST_MISC: begin
        ctrl.clr_all  = (act_q == kwm_pkg::ACT_CLEAR);
        ctrl.res_load = 1'b1;
      end
      default: ctrl = '0;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= kwm_pkg::ST_IDLE;
      cnt_q      <= '0;
      cand_vld_q <= 1'b0;
      found_q    <= 1'b0;
      done_q     <= 1'b0;
      for (int i = 0; i < NUM_LISTS; i++) begin
        wr_pos_q[i] <= '0;
        rd_pos_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      done_q  <= ctrl.res_load;
      if (accept) begin
        cnt_q      <= '0;
        cand_vld_q <= 1'b0;
        found_q    <= 1'b0;
      end else if (state_q == kwm_pkg::ST_SCAN) begin
        if (!scan_end) begin
          cnt_q <= cnt_q + CW'(1);
        end
        cand_vld_q <= issue && (rd_sel < wr_sel);
        if (take) begin
          found_q <= 1'b1;
        end
      end
      if (ctrl.wr_inc) begin
        wr_pos_q[pos_idx] <= wr_sel + PW'(1);
      end
      if (ctrl.rd_inc) begin
        rd_pos_q[pos_idx] <= rd_sel + PW'(1);
      end
      if (ctrl.clr_all) begin
        for (int i = 0; i < NUM_LISTS; i++) begin
          wr_pos_q[i] <= '0;
          rd_pos_q[i] <= '0;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q   <= action_i;
      list_q  <= list_number_i;
      value_q <= value_i;
    end
    if (issue) begin
      cand_idx_q <= cnt_q[LW-1:0];
    end
    if (take) begin
      best_q     <= cand_idx_q;
      best_val_q <= $signed(ram_rdata);
    end
    if (ctrl.res_load) begin
      case (state_q)
        kwm_pkg::ST_APPEND: begin
          res_val_q  <= '0;
          res_src_q  <= '0;
          res_stat_q <= append_ok ? kwm_pkg::STAT_OK : kwm_pkg::STAT_FULL;
        end
        kwm_pkg::ST_DONE: begin
          res_val_q  <= found_q ? best_val_q : '0;
          res_src_q  <= found_q ? 3'(best_q) : '0;
          res_stat_q <= found_q ? kwm_pkg::STAT_OK : kwm_pkg::STAT_EMPTY;
        end
        default: begin
          res_val_q  <= '0;
          res_src_q  <= '0;
          res_stat_q <= kwm_pkg::STAT_OK;
        end
      endcase
    end
  end

  assign done_o         = done_q;
  assign merged_value_o = res_val_q;
  assign source_list_o  = res_src_q;
  assign status_o       = res_stat_q;

endmodule

>>> rtl/kwm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module kwm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/kwm_checker.sv
// Port-level checker for the merge block, bound to the top level.
`include "assert_macros.svh"

module kwm_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               done_o,
  input logic signed [31:0] merged_value_o,
  input logic [2:0]         source_list_o,
  input logic [1:0]         status_o
);

  // An accepted word always makes the block busy in the next cycle.
  `KWM_ASSERT_NEXT(a_busy_after_start, start && !busy, busy)

  // The result appears when busy drops.
  `KWM_ASSERT_NOW(a_done_when_free, $fell(busy), done_o)

  // A result is never shown twice in a row.
  `KWM_ASSERT_NEXT(a_single_done, done_o, !done_o)

  // Only defined status codes are returned.
  `KWM_ASSERT_NOW(a_status_code, done_o,
    status_o == kwm_pkg::STAT_OK || status_o == kwm_pkg::STAT_FULL ||
    status_o == kwm_pkg::STAT_EMPTY)

  // A failed command carries zero payload.
  `KWM_ASSERT_NOW(a_fail_zero, done_o && status_o != kwm_pkg::STAT_OK,
    merged_value_o == 32'sd0 && source_list_o == 3'd0)

endmodule

bind k_way_merge kwm_checker u_kwm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .done_o         (done_o),
  .merged_value_o (merged_value_o),
  .source_list_o  (source_list_o),
  .status_o       (status_o)
);
